// ===== sv/wtq_pkg.sv =====
// Shared types and constants for the weighted token queue arbiter.
// No dependencies; imported by every module of the block.
`default_nettype none
package wtq_pkg;

  // Fixed slot count of the weight register file and queue index width
  localparam int QueueSlots   = 8;
  localparam int QidxW        = 3;
  localparam int MaskW        = 8;
  localparam int WeightW      = 8;
  localparam int CfgIdxW      = 4;
  localparam int NumQueuesDef = 8;

  localparam logic [WeightW-1:0] WeightRst = WeightW'(1);

  typedef logic [WeightW-1:0] weight_t;

  // Decision handed from the grant selector to the token bank
  typedef struct packed {
    logic             granted;
    logic [QidxW-1:0] idx;
    logic             reload;
  } grant_t;

endpackage
`default_nettype wire

// ===== sv/wtq_grant_sel.sv =====
// Grant selection: lowest non-empty queue with tokens, else one reload rescan.
// Depends on wtq_pkg.
`default_nettype none
module wtq_grant_sel import wtq_pkg::*; #(
  parameter int NUM_QUEUES = NumQueuesDef
) (
  input  wire logic [MaskW-1:0]      mask,
  input  wire logic [NUM_QUEUES-1:0] tok_nz,
  input  wire logic [NUM_QUEUES-1:0] wt_nz,
  output grant_t                     grant
);

  logic [NUM_QUEUES-1:0] active;
  logic [NUM_QUEUES-1:0] hit_tok;
  logic [NUM_QUEUES-1:0] hit_wt;
  logic [NUM_QUEUES-1:0] hit;
  logic                  reload;

  // Queues beyond the configured count never take part
  assign active  = mask[NUM_QUEUES-1:0];
  assign hit_tok = active & tok_nz;
  assign hit_wt  = active & wt_nz;

  // Reload when something is waiting but no waiting queue holds a token
  assign reload = (hit_tok == '0) && (active != '0);
  assign hit    = reload ? hit_wt : hit_tok;

  // Priority encode, lowest index wins
  always_comb begin
    grant.granted = 1'b0;
    grant.idx     = '0;
    grant.reload  = reload;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (hit[q]) begin
        grant.granted = 1'b1;
        grant.idx     = QidxW'(q);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/wtq_token_bank.sv =====
// Weight registers and per-queue token counters with reload and decrement.
// Depends on wtq_pkg.
`default_nettype none
module wtq_token_bank import wtq_pkg::*; #(
  parameter int NUM_QUEUES = NumQueuesDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIdxW-1:0]    cfg_index,
  input  wire logic [WeightW-1:0]    cfg_wdata,
  input  wire logic                  step,
  input  grant_t                     grant,
  output logic      [NUM_QUEUES-1:0] tok_nz,
  output logic      [NUM_QUEUES-1:0] wt_nz
);

  weight_t weight_r [QueueSlots];
  weight_t weight_nxt [QueueSlots];
  weight_t token_r [NUM_QUEUES];
  weight_t token_nxt [NUM_QUEUES];
  logic    cfg_hit;

  // Only writes that land on a weight register count
  assign cfg_hit = cfg_we && (cfg_index < CfgIdxW'(QueueSlots));

  // Weight register file; out-of-range indexes drop the write
  always_comb begin
    for (int s = 0; s < QueueSlots; s++) begin
      weight_nxt[s] = weight_r[s];
      if (cfg_we && (cfg_index == CfgIdxW'(s))) begin
        weight_nxt[s] = cfg_wdata;
      end
    end
  end

  // Token update: reload all on a weight write, else on a step reload on a rescan and consume on a grant
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      token_nxt[q] = token_r[q];
      if (cfg_hit) begin
        token_nxt[q] = weight_nxt[q];
      end else if (step) begin
        if (grant.reload) begin
          token_nxt[q] = weight_r[q];
        end
        if (grant.granted && (grant.idx == QidxW'(q))) begin
          token_nxt[q] = token_nxt[q] - WeightW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QueueSlots; s++) begin
        weight_r[s] <= WeightRst;
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
        token_r[q] <= WeightRst;
      end
    end else begin
      weight_r <= weight_nxt;
      token_r  <= token_nxt;
    end
  end

  // Zero flags feed the selector
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      tok_nz[q] = (token_r[q] != '0);
      wt_nz[q]  = (weight_r[q] != '0);
    end
  end

endmodule
`default_nettype wire

// ===== sv/weighted_token_queue_arbiter.sv =====
// Weighted token queue arbiter: one grant decision per request, one request
// per cycle while the result register is not stalled by out_ready. The
// request register feeds the grant selector, whose decision updates the
// token counters and loads the result register in the same cycle; a request
// passes the request register, then the result register. The token counter
// update loop sets the rate. A weight write reloads all token counters at once.
// Depends on wtq_pkg, wtq_grant_sel and wtq_token_bank.
`default_nettype none
module weighted_token_queue_arbiter import wtq_pkg::*; #(
  parameter int NUM_QUEUES = NumQueuesDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [MaskW-1:0]   in_nonempty_mask,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_granted,
  output logic      [QidxW-1:0]   out_queue_index,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WeightW-1:0] cfg_wdata
);

  logic                  in_vld_r;
  logic [MaskW-1:0]      mask_r;
  logic                  out_vld_r;
  logic                  granted_r;
  logic [QidxW-1:0]      qidx_r;
  logic                  advance;
  logic                  step;
  logic [NUM_QUEUES-1:0] tok_nz;
  logic [NUM_QUEUES-1:0] wt_nz;
  grant_t                grant;

  // Result register frees when empty or taken; request register follows
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;
  assign step     = in_vld_r && advance;

  // Hold the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mask_r <= in_nonempty_mask;
    end
  end

  wtq_grant_sel #(.NUM_QUEUES(NUM_QUEUES)) u_sel (
    .mask   (mask_r),
    .tok_nz (tok_nz),
    .wt_nz  (wt_nz),
    .grant  (grant)
  );

  wtq_token_bank #(.NUM_QUEUES(NUM_QUEUES)) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .grant     (grant),
    .tok_nz    (tok_nz),
    .wt_nz     (wt_nz)
  );

  // Advance the decision into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      granted_r <= grant.granted;
      qidx_r    <= grant.idx;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_granted     = granted_r;
  assign out_queue_index = qidx_r;

endmodule
`default_nettype wire

// ===== sv/wtq_checker.sv =====
// Port-level checks for the weighted token queue arbiter, bound to the top.
// Depends on wtq_pkg and weighted_token_queue_arbiter.
`default_nettype none
module wtq_checker import wtq_pkg::*; #(
  parameter int NUM_QUEUES = NumQueuesDef
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             out_granted,
  input wire logic [QidxW-1:0] out_queue_index
);

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A miss reports queue zero
  a_nogrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_queue_index == '0))
    else $error("no-grant result with nonzero queue index");

  // Only configured queues are granted
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> (32'(out_queue_index) < NUM_QUEUES))
    else $error("grant to queue beyond configured count");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_granted) && $stable(out_queue_index)))
    else $error("stalled result changed");

  // A stalled result keeps a full request register from draining
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !in_ready) |=> !(in_ready && !out_ready && out_valid &&
      !$past(in_valid && in_ready)))
    else $error("request register drained while result stalled");

endmodule

bind weighted_token_queue_arbiter wtq_checker #(.NUM_QUEUES(NUM_QUEUES)) u_wtq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_granted     (out_granted),
  .out_queue_index (out_queue_index)
);
`default_nettype wire
